FILE: design/rgb_to_hsv_converter_unit_assert.svh
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RHC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rhc_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Shared widths, constants, channel types and pipeline stage records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rhc_pkg;

    localparam int CHAN_W      = 8;
    localparam int OUT_W       = 15;
    localparam int PIPE_DEPTH  = 6;
    localparam int RECIP_SHIFT = 8;
    localparam int BRI_SHIFT   = 16;

    localparam int HUE_NUM_W  = 20;
    localparam int SAT_NUM_W  = 23;
    localparam int BRI_NUM_W  = 15;
    localparam int HUE_Q_W    = 12;
    localparam int SAT_Q_W    = 15;
    localparam int BRI_Q_W    = 7;
    localparam int HUE_FULL_W = CHAN_W + HUE_NUM_W;
    localparam int SAT_FULL_W = CHAN_W + SAT_NUM_W;
    localparam int BRI_FULL_W = BRI_NUM_W + CHAN_W + 1;
    localparam int HUE_SUM_W  = OUT_W + 1;

    localparam int HueSixth  = 3840;
    localparam int PctFull   = 25600;
    localparam int BriScale  = 100;
    localparam int BriRecip  = 257;
    localparam int ChanMax   = 255;

    localparam logic [OUT_W-1:0] HUE_TURN      = OUT_W'(23040);
    localparam logic [OUT_W-1:0] HUE_OFF_RED   = OUT_W'(0);
    localparam logic [OUT_W-1:0] HUE_OFF_GREEN = OUT_W'(7680);
    localparam logic [OUT_W-1:0] HUE_OFF_BLUE  = OUT_W'(15360);
    localparam logic [OUT_W-1:0] PCT_FULL_C    = OUT_W'(PctFull);

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_chan_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [OUT_W-1:0] hue;
        logic [OUT_W-1:0] saturation;
        logic [OUT_W-1:0] brightness;
    } hsv_t;

    typedef struct packed {
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] d;
        logic [CHAN_W-1:0] nmag;
        logic              neg;
        max_chan_t         sel;
        logic              grey;
    } s1_t;

    typedef struct packed {
        logic [CHAN_W-1:0]    mx;
        logic [CHAN_W-1:0]    d;
        logic [CHAN_W-1:0]    nmag;
        logic                 neg;
        max_chan_t            sel;
        logic                 grey;
        logic [HUE_NUM_W-1:0] hue_recip;
        logic [SAT_NUM_W-1:0] sat_recip;
        logic [HUE_NUM_W-1:0] hue_num;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [BRI_NUM_W-1:0] bri_num;
    } s2_t;

    typedef struct packed {
        logic [CHAN_W-1:0]    mx;
        logic [CHAN_W-1:0]    d;
        logic                 neg;
        max_chan_t            sel;
        logic                 grey;
        logic [HUE_NUM_W-1:0] hue_num;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [BRI_NUM_W-1:0] bri_num;
        logic [HUE_Q_W-1:0]   hue_est;
        logic [SAT_Q_W-1:0]   sat_est;
        logic [BRI_Q_W-1:0]   bri_est;
    } s3_t;

    typedef struct packed {
        logic [CHAN_W-1:0]    mx;
        logic [CHAN_W-1:0]    d;
        logic                 neg;
        max_chan_t            sel;
        logic                 grey;
        logic [HUE_NUM_W-1:0] hue_num;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [BRI_NUM_W-1:0] bri_num;
        logic [HUE_Q_W-1:0]   hue_est;
        logic [SAT_Q_W-1:0]   sat_est;
        logic [BRI_Q_W-1:0]   bri_est;
        logic [HUE_NUM_W-1:0] hue_prod;
        logic [SAT_NUM_W-1:0] sat_prod;
        logic [BRI_NUM_W-1:0] bri_prod;
    } s4_t;

    typedef struct packed {
        logic               neg;
        max_chan_t          sel;
        logic               grey;
        logic [HUE_Q_W-1:0] hue_q;
        logic [OUT_W-1:0]   saturation;
        logic [OUT_W-1:0]   brightness;
    } s5_t;

endpackage

FILE: design/rhc_if.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter channel interfaces
// Valid/ready channels for the pixel input and the HSV result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rhc_rgb_if;
    logic          valid;
    logic          ready;
    rhc_pkg::rgb_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rhc_hsv_if;
    logic          valid;
    logic          ready;
    rhc_pkg::hsv_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/rhc_extract.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter channel extraction stage
// Finds maximum, minimum, their difference and the signed hue numerator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhc_extract (
    input  logic          clk,
    input  logic          en,
    input  rhc_pkg::rgb_t pixel,
    output rhc_pkg::s1_t  s1
);
    import rhc_pkg::*;

    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;
    logic [CHAN_W:0]   num;
    logic [CHAN_W:0]   num_abs;
    s1_t               s1_next;
    s1_t               s1_reg;

    always_comb
    begin
        r  = pixel.red;
        g  = pixel.green;
        b  = pixel.blue;
        mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);

        if (mx == r)
        begin
            s1_next.sel = MAX_RED;
            num         = {1'b0, g} - {1'b0, b};
        end
        else if (mx == g)
        begin
            s1_next.sel = MAX_GREEN;
            num         = {1'b0, b} - {1'b0, r};
        end
        else
        begin
            s1_next.sel = MAX_BLUE;
            num         = {1'b0, r} - {1'b0, g};
        end

        num_abs      = num[CHAN_W] ? (~num + 1'b1) : num;
        s1_next.mx   = mx;
        s1_next.d    = mx - mn;
        s1_next.nmag = num_abs[CHAN_W-1:0];
        s1_next.neg  = num[CHAN_W];
        s1_next.grey = (mx == mn);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

FILE: design/rhc_recip.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter reciprocal lookup stage
// Reads scaled reciprocals of the divisors and forms the scaled dividends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhc_recip (
    input  logic         clk,
    input  logic         en,
    input  rhc_pkg::s1_t s1,
    output rhc_pkg::s2_t s2
);
    import rhc_pkg::*;

    localparam int Entries = 1 << CHAN_W;

    logic [HUE_NUM_W-1:0] hue_rom [Entries];
    logic [SAT_NUM_W-1:0] sat_rom [Entries];
    s2_t                  s2_next;
    s2_t                  s2_reg;

    // A zero divisor only occurs for grey pixels, whose results are forced later.
    assign hue_rom[0] = '0;
    assign sat_rom[0] = '0;

    for (genvar i = 1; i < Entries; i++)
    begin : g_rom
        localparam int HueEntry = (HueSixth << RECIP_SHIFT) / i;
        localparam int SatEntry = (PctFull << RECIP_SHIFT) / i;
        assign hue_rom[i] = HUE_NUM_W'(HueEntry);
        assign sat_rom[i] = SAT_NUM_W'(SatEntry);
    end

    always_comb
    begin
        s2_next.mx        = s1.mx;
        s2_next.d         = s1.d;
        s2_next.nmag      = s1.nmag;
        s2_next.neg       = s1.neg;
        s2_next.sel       = s1.sel;
        s2_next.grey      = s1.grey;
        s2_next.hue_recip = hue_rom[s1.d];
        s2_next.sat_recip = sat_rom[s1.mx];
        s2_next.hue_num   = HUE_NUM_W'(s1.nmag) * HUE_NUM_W'(HueSixth);
        s2_next.sat_num   = SAT_NUM_W'(s1.d) * SAT_NUM_W'(PctFull);
        s2_next.bri_num   = BRI_NUM_W'(s1.mx) * BRI_NUM_W'(BriScale);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

FILE: design/rhc_divide.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter divider stages
// Three stages: quotient estimate, back-multiplication and a one-step
// remainder correction for hue, saturation and brightness.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhc_divide (
    input  logic         clk,
    input  logic         en,
    input  rhc_pkg::s2_t s2,
    output rhc_pkg::s5_t s5
);
    import rhc_pkg::*;

    logic [HUE_FULL_W-1:0] hue_full;
    logic [SAT_FULL_W-1:0] sat_full;
    logic [BRI_FULL_W-1:0] bri_full;
    logic [HUE_NUM_W-1:0]  hue_rem;
    logic [SAT_NUM_W-1:0]  sat_rem;
    logic [BRI_NUM_W-1:0]  bri_rem;
    logic [SAT_Q_W-1:0]    sat_q;
    logic [BRI_Q_W-1:0]    bri_q;
    s3_t                   s3_next;
    s3_t                   s3_reg;
    s4_t                   s4_next;
    s4_t                   s4_reg;
    s5_t                   s5_next;
    s5_t                   s5_reg;

    // The estimates undershoot the true quotient by at most one.
    always_comb
    begin
        hue_full = HUE_FULL_W'(s2.nmag) * HUE_FULL_W'(s2.hue_recip);
        sat_full = SAT_FULL_W'(s2.d) * SAT_FULL_W'(s2.sat_recip);
        bri_full = BRI_FULL_W'(s2.bri_num) * BRI_FULL_W'(BriRecip);

        s3_next.mx      = s2.mx;
        s3_next.d       = s2.d;
        s3_next.neg     = s2.neg;
        s3_next.sel     = s2.sel;
        s3_next.grey    = s2.grey;
        s3_next.hue_num = s2.hue_num;
        s3_next.sat_num = s2.sat_num;
        s3_next.bri_num = s2.bri_num;
        s3_next.hue_est = hue_full[RECIP_SHIFT +: HUE_Q_W];
        s3_next.sat_est = sat_full[RECIP_SHIFT +: SAT_Q_W];
        s3_next.bri_est = bri_full[BRI_SHIFT +: BRI_Q_W];
    end

    always_comb
    begin
        s4_next.mx       = s3_reg.mx;
        s4_next.d        = s3_reg.d;
        s4_next.neg      = s3_reg.neg;
        s4_next.sel      = s3_reg.sel;
        s4_next.grey     = s3_reg.grey;
        s4_next.hue_num  = s3_reg.hue_num;
        s4_next.sat_num  = s3_reg.sat_num;
        s4_next.bri_num  = s3_reg.bri_num;
        s4_next.hue_est  = s3_reg.hue_est;
        s4_next.sat_est  = s3_reg.sat_est;
        s4_next.bri_est  = s3_reg.bri_est;
        s4_next.hue_prod = HUE_NUM_W'(s3_reg.hue_est) * HUE_NUM_W'(s3_reg.d);
        s4_next.sat_prod = SAT_NUM_W'(s3_reg.sat_est) * SAT_NUM_W'(s3_reg.mx);
        s4_next.bri_prod = BRI_NUM_W'(s3_reg.bri_est) * BRI_NUM_W'(ChanMax);
    end

    always_comb
    begin
        hue_rem = s4_reg.hue_num - s4_reg.hue_prod;
        sat_rem = s4_reg.sat_num - s4_reg.sat_prod;
        bri_rem = s4_reg.bri_num - s4_reg.bri_prod;
        sat_q   = s4_reg.sat_est + SAT_Q_W'(sat_rem >= SAT_NUM_W'(s4_reg.mx));
        bri_q   = s4_reg.bri_est + BRI_Q_W'(bri_rem >= BRI_NUM_W'(ChanMax));

        s5_next.neg        = s4_reg.neg;
        s5_next.sel        = s4_reg.sel;
        s5_next.grey       = s4_reg.grey;
        s5_next.hue_q      = s4_reg.hue_est + HUE_Q_W'(hue_rem >= HUE_NUM_W'(s4_reg.d));
        s5_next.saturation = s4_reg.grey ? '0 : OUT_W'(sat_q);
        s5_next.brightness = OUT_W'(s4_reg.bri_num) + OUT_W'(bri_q);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
        end
    end

    assign s5 = s5_reg;

endmodule

FILE: design/rhc_finish.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter output stage
// Applies the sector offset and sign to the hue, wraps it onto one turn and forces it to zero for grey pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhc_finish (
    input  logic          clk,
    input  logic          en,
    input  rhc_pkg::s5_t  s5,
    output rhc_pkg::hsv_t result
);
    import rhc_pkg::*;

    logic [HUE_SUM_W-1:0] offset;
    logic [HUE_SUM_W-1:0] sum;
    logic [HUE_SUM_W-1:0] wrapped;
    hsv_t                 result_next;
    hsv_t                 result_reg;

    always_comb
    begin
        case (s5.sel)
            MAX_RED:   offset = HUE_SUM_W'(HUE_OFF_RED);
            MAX_GREEN: offset = HUE_SUM_W'(HUE_OFF_GREEN);
            MAX_BLUE:  offset = HUE_SUM_W'(HUE_OFF_BLUE);
            default:   offset = HUE_SUM_W'(HUE_OFF_RED);
        endcase

        sum     = s5.neg ? (offset - HUE_SUM_W'(s5.hue_q)) : (offset + HUE_SUM_W'(s5.hue_q));
        wrapped = sum[HUE_SUM_W-1] ? (sum + HUE_SUM_W'(HUE_TURN)) : sum;

        result_next.hue        = s5.grey ? '0 : wrapped[OUT_W-1:0];
        result_next.saturation = s5.saturation;
        result_next.brightness = s5.brightness;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

FILE: design/rgb_to_hsv_converter_unit.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts one 8-bit RGB pixel per clock, while results are taken, into hue, saturation and brightness.
// ----------------------------------------------------------------------------
// The converter accepts one pixel transaction in every clock cycle while its
// results are taken. A pixel passes through six register stages: channel
// extraction, which captures the pixel at the accepting edge, reciprocal
// lookup, quotient estimate, back-multiplication, remainder correction and hue
// wrapping. Divisions use constant reciprocals, from tables for hue and
// saturation, with a single exact correction step. When a finished result is
// not taken, the whole pipeline holds and the input stops accepting
// transactions; nothing is lost or repeated. Hue is in units of 1/64 degree,
// saturation and brightness in units of 1/256 percent.
`timescale 1ns / 1ps

`include "rgb_to_hsv_converter_unit_assert.svh"

module rgb_to_hsv_converter_unit (
    input logic      clk,
    input logic      rst_n,
    rhc_rgb_if.sink  rgb,
    rhc_hsv_if.source hsv
);
    import rhc_pkg::*;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic                  advance;
    s1_t                   s1;
    s2_t                   s2;
    s5_t                   s5;
    hsv_t                  result;

    assign advance   = !valid_reg[PIPE_DEPTH-1] || hsv.ready;
    assign rgb.ready = advance;
    assign hsv.valid = valid_reg[PIPE_DEPTH-1];
    assign hsv.data  = result;

    always_comb
    begin
        valid_next = advance ? {valid_reg[PIPE_DEPTH-2:0], rgb.valid} : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    rhc_extract u_extract (
        .clk   (clk),
        .en    (advance),
        .pixel (rgb.data),
        .s1    (s1)
    );

    rhc_recip u_recip (
        .clk (clk),
        .en  (advance),
        .s1  (s1),
        .s2  (s2)
    );

    rhc_divide u_divide (
        .clk (clk),
        .en  (advance),
        .s2  (s2),
        .s5  (s5)
    );

    rhc_finish u_finish (
        .clk    (clk),
        .en     (advance),
        .s5     (s5),
        .result (result)
    );

    `RHC_ASSERT_IMP(a_hue_range, hsv.valid, hsv.data.hue < HUE_TURN, "Hue out of range.")
    `RHC_ASSERT_IMP(a_sat_range, hsv.valid, hsv.data.saturation <= PCT_FULL_C, "Saturation out of range.")
    `RHC_ASSERT_IMP(a_bri_range, hsv.valid, hsv.data.brightness <= PCT_FULL_C, "Brightness out of range.")
    `RHC_ASSERT_IMP(a_grey_hue, hsv.valid && (hsv.data.saturation == '0), hsv.data.hue == '0, "Grey hue not zero.")
    `RHC_ASSERT_NEXT(a_stall_hold, !advance, valid_reg == $past(valid_reg), "Pipeline moved during a stall.")

endmodule

FILE: test/hsv_result_checker.sv
// ----------------------------------------------------------------------------
// HSV result checker
// Watches the pixel and HSV channels of the RGB to HSV converter. For every
// accepted pixel it predicts the hue, saturation and brightness. It compares
// each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_result_checker
    import rhc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rhc_rgb_if   rgb,
    rhc_hsv_if   hsv,
    output int   mismatches,
    output int   pending,
    output int   checked
);

    typedef struct {
        rgb_t pixel;
        hsv_t result;
    } due_t;

    due_t hsv_due[$];
    int   error_count   = 0;
    int   compare_count = 0;
    int   queue_level   = 0;

    assign mismatches = error_count;
    assign pending    = queue_level;
    assign checked    = compare_count;

    // Red wins ties for the largest channel, and green wins over blue.
    function automatic hsv_t predict_hsv(input rgb_t px);
        int        r;
        int        g;
        int        b;
        int        mx;
        int        mn;
        int        d;
        int        num;
        int        off;
        int        h;
        int        sat;
        int        bri;
        max_chan_t top_chan;
        hsv_t      res;
        r  = px.red;
        g  = px.green;
        b  = px.blue;
        mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        d  = mx - mn;
        if (r >= g && r >= b)
            top_chan = MAX_RED;
        else if (g >= b)
            top_chan = MAX_GREEN;
        else
            top_chan = MAX_BLUE;
        if (d == 0)
        begin
            h = 0;
        end
        else
        begin
            case (top_chan)
                MAX_RED:
                begin
                    num = g - b;
                    off = int'(HUE_OFF_RED);
                end
                MAX_GREEN:
                begin
                    num = b - r;
                    off = int'(HUE_OFF_GREEN);
                end
                default:
                begin
                    num = r - g;
                    off = int'(HUE_OFF_BLUE);
                end
            endcase
            h = (HueSixth * num) / d + off;
            if (h < 0)
                h = h + int'(HUE_TURN);
            if (h >= int'(HUE_TURN))
                h = h - int'(HUE_TURN);
        end
        sat = (mx == 0) ? 0 : (d * PctFull) / mx;
        bri = (mx * PctFull) / ChanMax;
        res.hue        = OUT_W'(h);
        res.saturation = OUT_W'(sat);
        res.brightness = OUT_W'(bri);
        return res;
    endfunction

    always @(posedge clk)
    begin : monitor
        due_t entry;
        hsv_t got;
        if (rst_n)
        begin
            if (rgb.valid && rgb.ready)
            begin
                entry.pixel  = rgb.data;
                entry.result = predict_hsv(rgb.data);
                hsv_due.push_back(entry);
            end
            if (hsv.valid && hsv.ready)
            begin
                got = hsv.data;
                if (hsv_due.size() == 0)
                begin
                    $error("HSV transaction with no pixel outstanding: hue %0d, sat %0d, bri %0d",
                           got.hue, got.saturation, got.brightness);
                    error_count++;
                end
                else
                begin
                    entry = hsv_due.pop_front();
                    compare_count++;
                    if (got.hue !== entry.result.hue)
                    begin
                        $error("hue mismatch for pixel %h: expected %0d, actual %0d",
                               entry.pixel, entry.result.hue, got.hue);
                        error_count++;
                    end
                    if (got.saturation !== entry.result.saturation)
                    begin
                        $error("saturation mismatch for pixel %h: expected %0d, actual %0d",
                               entry.pixel, entry.result.saturation, got.saturation);
                        error_count++;
                    end
                    if (got.brightness !== entry.result.brightness)
                    begin
                        $error("brightness mismatch for pixel %h: expected %0d, actual %0d",
                               entry.pixel, entry.result.brightness, got.brightness);
                        error_count++;
                    end
                end
            end
            queue_level <= hsv_due.size();
        end
    end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Sends corner colours and then random pixels through the converter. The
// pixel and HSV channels are throttled in three patterns: a slow receiver,
// then a slow sender, then full-rate streaming. Results are checked by the
// HSV result checker, and a watchdog catches a stalled pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import rhc_pkg::*;

    localparam int RandomPerPhase = 610;
    localparam int WatchdogLimit  = 2000;

    logic clk;
    logic rst_n;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   stall_cycles  = 0;
    int   sent          = 0;
    int   mismatches;
    int   pending;
    int   checked;

    logic [23:0] corner_pixels [24] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFF0001, 24'hFF0100, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h010000,
        24'h000100, 24'h000001, 24'hC86432, 24'h0A141E, 24'hFEFFFD, 24'h010100,
        24'h000101, 24'h010001, 24'hFF8000, 24'h0080FF, 24'h7FFF80, 24'h55AAFF
    };

    rhc_rgb_if rgb ();
    rhc_hsv_if hsv ();

    rgb_to_hsv_converter_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rgb   (rgb),
        .hsv   (hsv)
    );

    hsv_result_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .rgb        (rgb),
        .hsv        (hsv),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        hsv.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            hsv.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((rgb.valid && rgb.ready) || (hsv.valid && hsv.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WatchdogLimit)
        begin
            $display("Watchdog: no transaction for %0d cycles.", WatchdogLimit);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_pixel(input rgb_t px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rgb.valid <= 1'b0;
            @(posedge clk);
        end
        rgb.valid <= 1'b1;
        rgb.data  <= px;
        do
            @(posedge clk);
        while (!rgb.ready);
        sent++;
    endtask

    task automatic drain_results();
        rgb.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Greys, ties for the largest channel and saturated colours are drawn
    // more often than plain random pixels would give them.
    function automatic rgb_t random_pixel();
        rgb_t       px;
        logic [7:0] level;
        int         kind;
        px    = 24'($urandom);
        level = 8'($urandom);
        kind  = $urandom_range(9);
        case (kind)
            0:
            begin
                px = {level, level, level};
            end
            1:
            begin
                px.red   = level;
                px.green = level;
                px.blue  = 8'($urandom_range(level));
            end
            2:
            begin
                px.green = level;
                px.blue  = level;
                px.red   = 8'($urandom_range(level));
            end
            3:
            begin
                px.red   = level;
                px.blue  = level;
                px.green = 8'($urandom_range(level));
            end
            4:
            begin
                px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
                px.green = $urandom_range(1) ? 8'hFF : 8'h00;
                px.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            5:
            begin
                px.red   = level;
                px.green = level ^ 8'($urandom_range(3));
                px.blue  = level ^ 8'($urandom_range(3));
            end
            default:
            begin
            end
        endcase
        return px;
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        rgb.valid     = 1'b0;
        rgb.data      = '0;
        send_idle_pct = 14;
        recv_idle_pct = 86;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (corner_pixels[i])
            send_pixel(rgb_t'(corner_pixels[i]));
        for (int i = 0; i < RandomPerPhase; i++)
            send_pixel(random_pixel());
        drain_results();

        send_idle_pct = 86;
        recv_idle_pct = 14;
        for (int i = 0; i < RandomPerPhase; i++)
            send_pixel(random_pixel());
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < RandomPerPhase; i++)
            send_pixel(random_pixel());
        drain_results();
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        $display("Checked %0d HSV results for %0d pixels: corner colours, greys, ties and random.",
                 checked, sent);
        $display("Flow control covered a slow receiver, a slow sender and full-rate streaming.");
        if (mismatches == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            if (pending != 0)
                $error("%0d pixel transactions never produced a result.", pending);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
